FILE: design/mps_pkg.sv
package mps_pkg;

  localparam int SLOTS   = 64;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int LEVELS  = 5;
  localparam int LVL_W   = 3;
  localparam int WAIT_W  = 16;
  localparam int TICK_W  = 32;
  localparam int TAG_W   = 16;
  localparam int AGE_N   = 4;
  localparam int CFG_W   = 2;

  localparam logic [LVL_W-1:0]  NOT_QUEUED = 3'd7;
  localparam logic [LVL_W-1:0]  TOP_LEVEL  = LVL_W'(LEVELS - 1);
  localparam logic [WAIT_W-1:0] WAIT_MAX   = '1;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_ADMIT  = 3'd1,
    OP_PICK   = 3'd2,
    OP_RETURN = 3'd3,
    OP_WAKE_C = 3'd4,
    OP_WAKE_S = 3'd5,
    OP_DEMOTE = 3'd6,
    OP_FREE   = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_UNUSED   = 3'd0,
    ST_RUNNABLE = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_SLEEPING = 3'd3,
    ST_FINISHED = 3'd4
  } status_t;

  localparam logic [1:0] NS_RUNNABLE = 2'd0;
  localparam logic [1:0] NS_SLEEPING = 2'd1;
  localparam logic [1:0] NS_FINISHED = 2'd2;

  localparam logic [1:0] CFG_AGE_ONE   = 2'd0;
  localparam logic [1:0] CFG_AGE_TWO   = 2'd1;
  localparam logic [1:0] CFG_AGE_THREE = 2'd2;
  localparam logic [1:0] CFG_AGE_FOUR  = 2'd3;

  typedef struct packed {
    logic [2:0]        status;
    logic [LVL_W-1:0]  qlvl;
    logic [LVL_W-1:0]  home;
    logic [WAIT_W-1:0] wait_cnt;
    logic [TICK_W-1:0] join_tick;
    logic [TAG_W-1:0]  tag;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  localparam rec_t REC_RESET = '{status: ST_UNUSED, qlvl: NOT_QUEUED, home: '0,
                                 wait_cnt: '0, join_tick: '0, tag: '0};

  typedef struct packed {
    logic start;
    logic rd;
    logic ex;
    logic pw;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic sweep;
    logic last;
    logic out_busy;
  } sts_t;

endpackage

FILE: design/mps_ram.sv
module mps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/mps_ctrl.sv
module mps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mps_pkg::sts_t sts,
  output mps_pkg::cmd_t cmd
);
  import mps_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_EX, S_PW, S_FIN} state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
        if (in_valid) state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EX;
      end
      S_EX: begin
        cmd.ex = 1'b1;
        if (sts.sweep && !sts.last) state_nxt = S_RD;
        else                        state_nxt = S_PW;
      end
      S_PW: begin
        cmd.pw    = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin = !sts.out_busy;
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

FILE: design/mps_dpath.sv
module mps_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mps_pkg::cmd_t               cmd,
  output mps_pkg::sts_t               sts,
  input  logic [2:0]                  in_operation,
  input  logic [mps_pkg::IDX_W-1:0]   in_slot,
  input  logic [1:0]                  in_new_status,
  input  logic [mps_pkg::TAG_W-1:0]   in_channel,
  input  logic                        cfg_valid,
  input  logic [mps_pkg::CFG_W-1:0]   cfg_index,
  input  logic [mps_pkg::WAIT_W-1:0]  cfg_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_found,
  output logic [mps_pkg::IDX_W-1:0]   out_chosen_slot,
  output logic [mps_pkg::LVL_W-1:0]   out_chosen_level
);
  import mps_pkg::*;

  logic [WAIT_W-1:0] age_r [AGE_N];
  logic [TICK_W-1:0] tick_r;
  op_t               op_r;
  logic [1:0]        ns_r;
  logic [TAG_W-1:0]  chan_r;
  logic [IDX_W-1:0]  idx_r;
  logic              found_r, found_nxt;
  logic              bfound_r;
  logic [IDX_W-1:0]  bidx_r;
  rec_t              brec_r;
  logic [SLOTS-1:0]  vld_r;
  logic              out_valid_r, out_found_r;
  logic [IDX_W-1:0]  out_slot_r;
  logic [LVL_W-1:0]  out_lvl_r;

  logic [REC_W-1:0]  ram_q;
  rec_t              cur, upd;
  logic              wr_ex, take, promote;
  logic [WAIT_W-1:0] thr;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  rec_t              wrec;

  mps_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wrec),
    .re   (cmd.rd),
    .raddr(idx_r),
    .rdata(ram_q)
  );

  assign cur = vld_r[idx_r] ? rec_t'(ram_q) : REC_RESET;

  always_comb begin
    if (cur.qlvl > LVL_W'(AGE_N) || cur.qlvl == '0) thr = age_r[AGE_N-1];
    else                                          thr = age_r[2'(cur.qlvl - 3'd1)];
  end

  // Per-slot update for the operation in flight.
  always_comb begin
    upd       = cur;
    wr_ex     = 1'b0;
    found_nxt = found_r;
    take      = 1'b0;
    promote   = 1'b0;
    case (op_r)
      OP_TICK: begin
        wr_ex = 1'b1;
        if ((cur.status == ST_SLEEPING || cur.status == ST_RUNNABLE)
            && cur.wait_cnt != WAIT_MAX) begin
          upd.wait_cnt = cur.wait_cnt + 1'b1;
        end
      end
      OP_ADMIT: begin
        if (cur.status == ST_UNUSED) begin
          wr_ex = 1'b1; found_nxt = 1'b1;
          upd.status = ST_RUNNABLE; upd.home = '0; upd.qlvl = '0;
          upd.wait_cnt = '0; upd.join_tick = tick_r;
        end
      end
      OP_PICK: begin
        wr_ex   = 1'b1;
        promote = cur.status == ST_RUNNABLE && cur.qlvl != '0 && cur.wait_cnt >= thr;
        if (promote) begin
          upd.wait_cnt  = '0;
          upd.join_tick = tick_r;
          upd.qlvl      = cur.qlvl - 1'b1;
          if (cur.home != '0) upd.home = cur.home - 1'b1;
        end
        if (upd.status == ST_RUNNABLE && upd.qlvl < LVL_W'(LEVELS)) begin
          if (!bfound_r || upd.qlvl < brec_r.qlvl) take = 1'b1;
          else if (upd.qlvl == brec_r.qlvl)
            take = (upd.qlvl != TOP_LEVEL) || (upd.join_tick < brec_r.join_tick);
        end
      end
      OP_RETURN: begin
        if (cur.status == ST_RUNNING && ns_r != 2'd3) begin
          wr_ex = 1'b1; found_nxt = 1'b1;
          if (ns_r == NS_FINISHED) begin
            upd.status = ST_FINISHED;
          end else begin
            upd.status    = (ns_r == NS_RUNNABLE) ? ST_RUNNABLE : ST_SLEEPING;
            if (ns_r == NS_SLEEPING) upd.tag = chan_r;
            upd.wait_cnt  = '0;
            upd.join_tick = tick_r;
            upd.qlvl      = cur.home;
          end
        end
      end
      OP_WAKE_C, OP_WAKE_S: begin
        if (cur.status == ST_SLEEPING && (op_r == OP_WAKE_S || cur.tag == chan_r)) begin
          wr_ex = 1'b1; found_nxt = 1'b1;
          upd.status = ST_RUNNABLE; upd.wait_cnt = '0;
          upd.join_tick = tick_r; upd.qlvl = cur.home;
        end
      end
      OP_DEMOTE: begin
        if (cur.status != ST_UNUSED && cur.home < TOP_LEVEL) begin
          wr_ex = 1'b1; found_nxt = 1'b1;
          upd.home = cur.home + 1'b1;
        end
      end
      OP_FREE: begin
        if (cur.status == ST_FINISHED) begin
          wr_ex = 1'b1; found_nxt = 1'b1;
          upd = REC_RESET;
          upd.tag = cur.tag;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    we    = (cmd.ex && wr_ex) || (cmd.pw && bfound_r);
    waddr = cmd.pw ? bidx_r : idx_r;
    wrec  = upd;
    if (cmd.pw) begin
      wrec        = brec_r;
      wrec.status = ST_RUNNING;
      wrec.qlvl   = NOT_QUEUED;
    end
  end

  assign sts.sweep    = op_r == OP_TICK || op_r == OP_PICK || op_r == OP_WAKE_C;
  assign sts.last     = idx_r == IDX_W'(SLOTS - 1);
  assign sts.out_busy = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_r[0]    <= WAIT_W'(20);
      age_r[1]    <= WAIT_W'(30);
      age_r[2]    <= WAIT_W'(40);
      age_r[3]    <= WAIT_W'(50);
      tick_r      <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      bfound_r    <= 1'b0;
    end else begin
      if (cfg_valid) age_r[cfg_index] <= cfg_data;
      if (we) vld_r[waddr] <= 1'b1;
      if (cmd.start) begin
        op_r     <= op_t'(in_operation);
        ns_r     <= in_new_status;
        chan_r   <= in_channel;
        found_r  <= op_t'(in_operation) == OP_TICK;
        bfound_r <= 1'b0;
        idx_r    <= (op_t'(in_operation) == OP_TICK || op_t'(in_operation) == OP_PICK
                     || op_t'(in_operation) == OP_WAKE_C) ? '0 : in_slot;
        if (op_t'(in_operation) == OP_TICK) tick_r <= tick_r + 1'b1;
      end
      if (cmd.ex) begin
        found_r <= found_nxt;
        if (take) begin
          bfound_r <= 1'b1;
          bidx_r   <= idx_r;
          brec_r   <= upd;
        end
        if (sts.sweep && !sts.last) idx_r <= idx_r + 1'b1;
      end
      if (cmd.fin) begin
        out_valid_r <= 1'b1;
        if (op_r == OP_PICK) begin
          out_found_r <= bfound_r;
          out_slot_r  <= bfound_r ? bidx_r : '0;
          out_lvl_r   <= bfound_r ? brec_r.qlvl : '0;
        end else begin
          out_found_r <= found_r;
          out_slot_r  <= '0;
          out_lvl_r   <= '0;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_chosen_slot  = out_slot_r;
  assign out_chosen_level = out_lvl_r;

endmodule

FILE: design/mlfq_process_selector.sv
// Five-level feedback-queue task selector over a 64-slot table held in one
// RAM (one record per slot, registered read). Every item reads, then updates
// each slot it visits in turn: tick, pick and wake-channel sweep all 64 slots,
// the other events touch one slot. The RAM has a single read port and a
// single write port, so slots are visited one at a time. A pick ages and
// selects in the same sweep, then writes the chosen slot as running. Slot
// records carry a valid bit each, cleared by reset, so no clearing pass is
// needed. The next item is taken once the current one has finished; a
// result waits in the output register until taken. cfg_ready is always high.
module mlfq_process_selector (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  in_operation,
  input  logic [mps_pkg::IDX_W-1:0]   in_slot,
  input  logic [1:0]                  in_new_status,
  input  logic [mps_pkg::TAG_W-1:0]   in_channel,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mps_pkg::CFG_W-1:0]   cfg_index,
  input  logic [mps_pkg::WAIT_W-1:0]  cfg_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_found,
  output logic [mps_pkg::IDX_W-1:0]   out_chosen_slot,
  output logic [mps_pkg::LVL_W-1:0]   out_chosen_level
);
  import mps_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  // Sequence read, update and writeback of slots.
  mps_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Hold the slot table, thresholds, tick counter and result register.
  mps_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_operation),
    .in_slot         (in_slot),
    .in_new_status   (in_new_status),
    .in_channel      (in_channel),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_chosen_slot (out_chosen_slot),
    .out_chosen_level(out_chosen_level)
  );

endmodule
